// ===== rtl/pixel_hit_clusterer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// pixel_hit_clusterer_unit_defines
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef PIXEL_HIT_CLUSTERER_UNIT_DEFINES_SVH
`define PIXEL_HIT_CLUSTERER_UNIT_DEFINES_SVH

// same-cycle implication, reset held off
`define PHC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pixel_hit_clusterer_unit: check failed");

// next-cycle implication, reset held off
`define PHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pixel_hit_clusterer_unit: check failed");

`endif

// ===== rtl/phc_pkg.sv =====
// ----------------------------------------------------------------------------
// phc_pkg
// Types, constants and helpers of the pixel hit clusterer.
// ----------------------------------------------------------------------------
package phc_pkg;

  localparam int unsigned COL_W = 10;
  localparam int unsigned ROW_W = 10;
  localparam int unsigned LAY_W = 6;
  localparam int unsigned HE_W  = 24;
  localparam int unsigned CE_W  = 30;
  localparam int unsigned RAD_W = 5;

  localparam logic [CE_W-1:0] ENERGY_MAX      = {CE_W{1'b1}};
  localparam logic [CE_W-1:0] THRESHOLD_RESET = 30'd100000;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [LAY_W-1:0] layer;
    logic [HE_W-1:0]  energy;
  } hit_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [LAY_W-1:0] layer;
    logic [CE_W-1:0]  energy;
  } clu_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_SEED_RD,
    S_SEED_LD,
    S_CL_RD,
    S_CL_CMP,
    S_ACC_RD,
    S_ACC_CMP,
    S_WRITE,
    S_OUT_RD,
    S_OUT_LD,
    S_OUT_SHOW
  } state_t;

  typedef struct packed {
    logic load_hit;
    logic start;
    logic hit_sel_k;
    logic clu_sel_out;
    logic clr_j;
    logic latch_seed;
    logic next_j;
    logic next_i;
    logic init_acc;
    logic acc_step;
    logic write_clu;
    logic start_out;
    logic load_out;
    logic next_out;
    logic end_evt;
  } cmd_t;

  typedef struct packed {
    logic i_done;
    logic j_done;
    logic k_done;
    logic near_clu;
    logic out_last;
  } status_t;

  // same layer, column and row each differing by less than radius
  function automatic logic near_f(
    input logic [COL_W-1:0] col_a,
    input logic [ROW_W-1:0] row_a,
    input logic [LAY_W-1:0] lay_a,
    input logic [COL_W-1:0] col_b,
    input logic [ROW_W-1:0] row_b,
    input logic [LAY_W-1:0] lay_b,
    input logic [RAD_W-1:0] radius
  );
    logic [COL_W-1:0] dc;
    logic [ROW_W-1:0] dr;
    dc = (col_a >= col_b) ? col_a - col_b : col_b - col_a;
    dr = (row_a >= row_b) ? row_a - row_b : row_b - row_a;
    return (lay_a == lay_b) && ({1'b0, dc} < (COL_W + 1)'(radius)) &&
           ({1'b0, dr} < (ROW_W + 1)'(radius));
  endfunction

endpackage

// ===== rtl/phc_ctrl.sv =====
// ----------------------------------------------------------------------------
// phc_ctrl
// Sequencer: hit loading, cluster search, seed accumulation, cluster output.
// ----------------------------------------------------------------------------
module phc_ctrl
  import phc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_last_hit,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD: begin
        if (in_valid && in_last_hit) state_nxt = S_SEED_RD;
      end
      S_SEED_RD:  state_nxt = st.i_done ? S_OUT_RD : S_SEED_LD;
      S_SEED_LD:  state_nxt = S_CL_RD;
      S_CL_RD:    state_nxt = st.j_done ? S_ACC_RD : S_CL_CMP;
      S_CL_CMP:   state_nxt = st.near_clu ? S_SEED_RD : S_CL_RD;
      S_ACC_RD:   state_nxt = st.k_done ? S_WRITE : S_ACC_CMP;
      S_ACC_CMP:  state_nxt = S_ACC_RD;
      S_WRITE:    state_nxt = S_SEED_RD;
      S_OUT_RD:   state_nxt = S_OUT_LD;
      S_OUT_LD:   state_nxt = S_OUT_SHOW;
      S_OUT_SHOW: begin
        if (!out_stall) state_nxt = st.out_last ? S_LOAD : S_OUT_RD;
      end
      default:    state_nxt = S_LOAD;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_LOAD: begin
        in_stall     = 1'b0;
        cmd.load_hit = in_valid;
        cmd.start    = in_valid && in_last_hit;
      end
      S_SEED_RD: begin
        cmd.start_out = st.i_done;
        cmd.clr_j     = !st.i_done;
      end
      S_SEED_LD: cmd.latch_seed = 1'b1;
      S_CL_RD:   cmd.init_acc = st.j_done;
      S_CL_CMP: begin
        cmd.next_i = st.near_clu;
        cmd.next_j = !st.near_clu;
      end
      S_ACC_RD:  cmd.hit_sel_k = 1'b1;
      S_ACC_CMP: begin
        cmd.hit_sel_k = 1'b1;
        cmd.acc_step  = 1'b1;
      end
      S_WRITE:   cmd.write_clu = 1'b1;
      S_OUT_RD:  cmd.clu_sel_out = 1'b1;
      S_OUT_LD: begin
        cmd.clu_sel_out = 1'b1;
        cmd.load_out    = 1'b1;
      end
      S_OUT_SHOW: begin
        out_valid    = 1'b1;
        cmd.end_evt  = !out_stall && st.out_last;
        cmd.next_out = !out_stall && !st.out_last;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/phc_dp.sv =====
// ----------------------------------------------------------------------------
// phc_dp
// Hit and cluster stores, index counters, accumulator and output register.
// ----------------------------------------------------------------------------
module phc_dp
  import phc_pkg::*;
#(
  parameter int unsigned MAX_HITS        = 64,
  parameter int unsigned NEIGHBOR_RADIUS = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output status_t          st,
  input  hit_t             hit_in,
  input  logic             cfg_we,
  input  logic [CE_W-1:0]  cfg_data,
  output clu_t             out_clu,
  output logic             out_above,
  output logic             out_last
);

  localparam int unsigned CW = $clog2(MAX_HITS + 1);
  localparam int unsigned AW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_HITS);
  localparam logic [RAD_W-1:0] RADIUS = RAD_W'(NEIGHBOR_RADIUS);

  hit_t hit_mem [MAX_HITS];
  clu_t clu_mem [MAX_HITS];

  hit_t hit_rd_r;
  clu_t clu_rd_r;
  hit_t seed_r;
  clu_t acc_r, acc_nxt;
  clu_t out_r;
  logic out_above_r, out_last_r;
  logic [CE_W-1:0] thr_r;
  logic [CW-1:0] hit_cnt_r, clu_cnt_r, i_r, j_r, k_r, m_r;
  logic [CW-1:0] hit_addr, clu_addr;
  logic [CE_W:0] sum;
  logic          near_acc;

  assign hit_addr = cmd.hit_sel_k ? k_r : i_r;
  assign clu_addr = cmd.clu_sel_out ? m_r : j_r;

  always_ff @(posedge clk) begin
    if (cmd.load_hit && (hit_cnt_r < MAX_CNT)) begin
      hit_mem[hit_cnt_r[AW-1:0]] <= hit_in;
    end
    hit_rd_r <= hit_mem[hit_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.write_clu) begin
      clu_mem[clu_cnt_r[AW-1:0]] <= acc_r;
    end
    clu_rd_r <= clu_mem[clu_addr[AW-1:0]];
  end

  assign near_acc = near_f(seed_r.col, seed_r.row, seed_r.layer,
                           hit_rd_r.col, hit_rd_r.row, hit_rd_r.layer, RADIUS);
  assign sum = {1'b0, acc_r.energy} + (CE_W + 1)'(hit_rd_r.energy);

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.init_acc) begin
      acc_nxt = '{col: seed_r.col, row: seed_r.row, layer: seed_r.layer,
                  energy: CE_W'(seed_r.energy)};
    end else if (cmd.acc_step && near_acc) begin
      // representative moves when the hit outweighs the running sum
      if (CE_W'(hit_rd_r.energy) > acc_r.energy) begin
        acc_nxt.col   = hit_rd_r.col;
        acc_nxt.row   = hit_rd_r.row;
        acc_nxt.layer = hit_rd_r.layer;
      end
      acc_nxt.energy = sum[CE_W] ? ENERGY_MAX : sum[CE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (cmd.latch_seed) seed_r <= hit_rd_r;
    if (cmd.load_out) begin
      out_r       <= clu_rd_r;
      out_above_r <= clu_rd_r.energy > thr_r;
      out_last_r  <= (m_r + 1'b1) == clu_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= THRESHOLD_RESET;
      hit_cnt_r <= '0;
      clu_cnt_r <= '0;
      i_r       <= '0;
      j_r       <= '0;
      k_r       <= '0;
      m_r       <= '0;
    end else begin
      if (cfg_we) thr_r <= cfg_data;
      if (cmd.end_evt) begin
        hit_cnt_r <= '0;
      end else if (cmd.load_hit && (hit_cnt_r < MAX_CNT)) begin
        hit_cnt_r <= hit_cnt_r + 1'b1;
      end
      if (cmd.start) begin
        i_r       <= '0;
        clu_cnt_r <= '0;
      end else if (cmd.write_clu) begin
        i_r       <= i_r + 1'b1;
        clu_cnt_r <= clu_cnt_r + 1'b1;
      end else if (cmd.next_i) begin
        i_r <= i_r + 1'b1;
      end
      if (cmd.clr_j) j_r <= '0;
      else if (cmd.next_j) j_r <= j_r + 1'b1;
      if (cmd.init_acc) k_r <= i_r + 1'b1;
      else if (cmd.acc_step) k_r <= k_r + 1'b1;
      if (cmd.start_out) m_r <= '0;
      else if (cmd.next_out) m_r <= m_r + 1'b1;
    end
  end

  assign st.i_done   = i_r == hit_cnt_r;
  assign st.j_done   = j_r == clu_cnt_r;
  assign st.k_done   = k_r == hit_cnt_r;
  assign st.near_clu = near_f(clu_rd_r.col, clu_rd_r.row, clu_rd_r.layer,
                              seed_r.col, seed_r.row, seed_r.layer, RADIUS);
  assign st.out_last = out_last_r;

  assign out_clu   = out_r;
  assign out_above = out_above_r;
  assign out_last  = out_last_r;

endmodule

// ===== rtl/pixel_hit_clusterer_unit.sv =====
// Hits are stored as they are taken in; after the last hit, each stored hit is compared
// with the clusters found so far, and each new seed accumulates the later hits near it.
// Clusters then leave one by one (one cluster store read per result).
// The pairwise scan through the hit and cluster stores sets the rate.
// Reset (synchronous, rst_n low) empties the event and sets the threshold to 100000.
// ----------------------------------------------------------------------------
// pixel_hit_clusterer_unit
// Collects one event's pixel hits and emits their clusters.
// ----------------------------------------------------------------------------
module pixel_hit_clusterer_unit
  import phc_pkg::*;
#(
  parameter int unsigned MAX_HITS        = 64,
  parameter int unsigned NEIGHBOR_RADIUS = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CE_W-1:0]  cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [COL_W-1:0] in_pixel_col,
  input  logic [ROW_W-1:0] in_pixel_row,
  input  logic [LAY_W-1:0] in_layer_index,
  input  logic [HE_W-1:0]  in_hit_energy,
  input  logic             in_last_hit,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [COL_W-1:0] out_cluster_col,
  output logic [ROW_W-1:0] out_cluster_row,
  output logic [LAY_W-1:0] out_cluster_layer,
  output logic [CE_W-1:0]  out_cluster_energy,
  output logic             out_above_threshold,
  output logic             out_last_cluster
);

  cmd_t    cmd;
  status_t st;
  hit_t    hit_in;
  clu_t    out_clu;

  assign hit_in = '{col: in_pixel_col, row: in_pixel_row, layer: in_layer_index,
                    energy: in_hit_energy};

  phc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_last_hit(in_last_hit),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .st         (st),
    .cmd        (cmd)
  );

  phc_dp #(
    .MAX_HITS       (MAX_HITS),
    .NEIGHBOR_RADIUS(NEIGHBOR_RADIUS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .st       (st),
    .hit_in   (hit_in),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .out_clu  (out_clu),
    .out_above(out_above_threshold),
    .out_last (out_last_cluster)
  );

  assign out_cluster_col    = out_clu.col;
  assign out_cluster_row    = out_clu.row;
  assign out_cluster_layer  = out_clu.layer;
  assign out_cluster_energy = out_clu.energy;

endmodule

// ===== rtl/phc_checker.sv =====
// ----------------------------------------------------------------------------
// phc_checker
// Port-level checks of the pixel hit clusterer, bound to the top level.
// ----------------------------------------------------------------------------
`include "pixel_hit_clusterer_unit_defines.svh"

module phc_checker
  import phc_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input logic            in_last_hit,
  input logic            out_valid,
  input logic            out_stall,
  input logic [CE_W-1:0] out_cluster_energy
);

  // no hit taken while clusters are being delivered
  `PHC_ASSERT_NOW(a_no_intake_on_out, clk, rst_n, out_valid, in_stall)
  // a hit without the last flag never produces a result
  `PHC_ASSERT_NEXT(a_no_early_out, clk, rst_n, in_valid && !in_stall && !in_last_hit, !out_valid)
  `PHC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `PHC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_cluster_energy))

endmodule

bind pixel_hit_clusterer_unit phc_checker u_phc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_last_hit       (in_last_hit),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_cluster_energy(out_cluster_energy)
);

// ===== test/pixel_hit_clusterer_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pixel_hit_clusterer_unit_tb
// Feeds hit events through the clusterer and checks each emitted cluster.
// The expected clusters come from a behavioral clustering model in this file.
// ----------------------------------------------------------------------------
module pixel_hit_clusterer_unit_tb;
  import phc_pkg::*;

  localparam int MAX_HITS   = 64;
  localparam int RADIUS     = 3;
  localparam int STALL_LIM  = 200000;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [LAY_W-1:0] layer;
    logic [HE_W-1:0]  energy;
    logic             last;
  } beat_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [LAY_W-1:0] layer;
    logic [CE_W-1:0]  energy;
    logic             above;
    logic             last;
  } cluster_beat_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CE_W-1:0]  cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [COL_W-1:0] in_pixel_col = '0;
  logic [ROW_W-1:0] in_pixel_row = '0;
  logic [LAY_W-1:0] in_layer_index = '0;
  logic [HE_W-1:0]  in_hit_energy = '0;
  logic             in_last_hit = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b1;
  logic [COL_W-1:0] out_cluster_col;
  logic [ROW_W-1:0] out_cluster_row;
  logic [LAY_W-1:0] out_cluster_layer;
  logic [CE_W-1:0]  out_cluster_energy;
  logic             out_above_threshold;
  logic             out_last_cluster;

  pixel_hit_clusterer_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  beat_t          hit_queue[$];
  cluster_beat_t  cluster_queue[$];
  beat_t          event_hits[$];
  logic [CE_W-1:0] threshold = THRESHOLD_RESET;
  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  calm = 1'b0;
  bit  timed_out = 1'b0;
  bit  stim_done = 1'b0;

  function automatic bit hits_near(beat_t a, beat_t b);
    int dc, dr;
    dc = int'(a.col) - int'(b.col);
    dr = int'(a.row) - int'(b.row);
    if (dc < 0) dc = -dc;
    if (dr < 0) dr = -dr;
    return a.layer == b.layer && dc < RADIUS && dr < RADIUS;
  endfunction

  // clusters one event; hits is already truncated to MAX_HITS
  task automatic predict_clusters();
    beat_t         seeds[$];
    cluster_beat_t found[$];
    cluster_beat_t c;
    beat_t         rep;
    bit            taken;
    logic [CE_W:0] sum;
    for (int i = 0; i < event_hits.size(); i++) begin
      taken = 1'b0;
      foreach (found[j]) begin
        rep = '{found[j].col, found[j].row, found[j].layer, '0, 1'b0};
        if (hits_near(rep, event_hits[i])) taken = 1'b1;
      end
      if (taken) continue;
      c = '{event_hits[i].col, event_hits[i].row, event_hits[i].layer,
            CE_W'(event_hits[i].energy), 1'b0, 1'b0};
      for (int k = i + 1; k < event_hits.size(); k++) begin
        if (hits_near(event_hits[i], event_hits[k])) begin
          if (CE_W'(event_hits[k].energy) > c.energy) begin
            c.col = event_hits[k].col;
            c.row = event_hits[k].row;
            c.layer = event_hits[k].layer;
          end
          sum = c.energy + event_hits[k].energy;
          c.energy = sum > ENERGY_MAX ? ENERGY_MAX : sum[CE_W-1:0];
        end
      end
      found.push_back(c);
    end
    foreach (found[j]) begin
      found[j].above = found[j].energy > threshold;
      found[j].last = (j == found.size() - 1);
      cluster_queue.push_back(found[j]);
    end
    event_hits.delete();
  endtask

  // driver
  always @(posedge clk) begin
    beat_t b;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        b = '{in_pixel_col, in_pixel_row, in_layer_index, in_hit_energy, in_last_hit};
        if (event_hits.size() < MAX_HITS) event_hits.push_back(b);
        if (b.last) predict_clusters();
      end
      if (!in_valid || !in_stall) begin
        if (hit_queue.size() > 0 && (calm || $urandom_range(99) >= 21)) begin
          b = hit_queue.pop_front();
          in_valid <= 1'b1;
          {in_pixel_col, in_pixel_row, in_layer_index, in_hit_energy, in_last_hit} <= b;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 21);
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    cluster_beat_t got, want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_cluster_col, out_cluster_row, out_cluster_layer,
                out_cluster_energy, out_above_threshold, out_last_cluster};
        if (cluster_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected cluster beat %h", got);
        end else begin
          want = cluster_queue.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("cluster mismatch: expected %h got %h", want, got);
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIM) timed_out <= 1'b1;
    end
  end

  function automatic beat_t rand_hit(int cbase, int rbase, int lay, bit last);
    beat_t b;
    b.col = COL_W'(cbase + $urandom_range(4));
    b.row = ROW_W'(rbase + $urandom_range(4));
    b.layer = LAY_W'(lay);
    case ($urandom_range(5))
      0: b.energy = '1;
      1: b.energy = HE_W'($urandom_range(200));
      default: b.energy = HE_W'($urandom);
    endcase
    b.last = last;
    return b;
  endfunction

  task automatic push_event(int n, bit clustered);
    int cb, rb, lay;
    cb = $urandom_range(1023);
    rb = $urandom_range(1023);
    lay = $urandom_range(63);
    for (int i = 0; i < n; i++) begin
      if (!clustered) begin
        cb = $urandom_range(1023);
        rb = $urandom_range(1023);
        lay = $urandom_range(63);
      end else if ($urandom_range(3) == 0) begin
        lay = $urandom_range(1) ? lay : $urandom_range(63);
      end
      hit_queue.push_back(rand_hit(cb, rb, lay, i == n - 1));
    end
  endtask

  task automatic wait_drained();
    while (!timed_out && (hit_queue.size() > 0 || in_valid || cluster_queue.size() > 0))
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_threshold(logic [CE_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    threshold = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int sent;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // directed: single hit extremes, zero and full energy, full-energy pile-up
    hit_queue.push_back('{'0, '0, '0, '0, 1'b1});
    hit_queue.push_back('{'1, '1, '1, '1, 1'b1});
    hit_queue.push_back('{10'd5, 10'd5, 6'd3, 24'd100, 1'b0});
    hit_queue.push_back('{10'd7, 10'd7, 6'd3, 24'd500, 1'b0}); // just inside radius
    hit_queue.push_back('{10'd8, 10'd5, 6'd3, 24'd50, 1'b0});  // just outside
    hit_queue.push_back('{10'd5, 10'd5, 6'd4, 24'd50, 1'b1});  // other layer
    for (int i = 0; i < 70; i++)  // overfills the store, sum just below saturation
      hit_queue.push_back('{10'd512, 10'd512, 6'd9, '1, i == 69});
    push_event(4, 1'b1);
    wait_drained();
    write_threshold('0);
    calm = 1'b1;
    push_event(20, 1'b1);
    wait_drained();
    calm = 1'b0;
    write_threshold(ENERGY_MAX);
    push_event(10, 1'b1);
    wait_drained();
    write_threshold(30'd20000000);
    sent = 0;
    while (sent < 400) begin
      int n;
      n = ($urandom_range(9) == 0) ? $urandom_range(64) + 1 : $urandom_range(12) + 1;
      push_event(n, $urandom_range(3) != 0);
      sent += n;
      if ($urandom_range(7) == 0) begin
        wait_drained();
        write_threshold($urandom_range(1) ? CE_W'($urandom) : CE_W'($urandom_range(50000000)));
      end
    end
    wait_drained();
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done || timed_out);
    if (!timed_out && mismatches == 0 && cluster_queue.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
